@@ hw/rtl/imm_pkg.sv @@
// shared types and constants for the interleaved modular multiplier
package imm_pkg;

	localparam int unsigned DEF_WIDTH = 64;
	localparam int unsigned ACC_GUARD = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		SEL_KEEP,
		SEL_SUB1,
		SEL_SUB2
	} sel_t;

	typedef struct packed {
		logic load;
		logic step;
		logic abit;
	} cell_ctl_t;

endpackage

@@ hw/rtl/imm_if.sv @@
// valid/ready channel interfaces for operand and result items
interface imm_in_if #(
	parameter int unsigned WIDTH = imm_pkg::DEF_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] multiplicand;
	logic [WIDTH-1:0] multiplier;

	modport source (output valid, output multiplicand, output multiplier, input ready);
	modport sink (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface imm_out_if #(
	parameter int unsigned WIDTH = imm_pkg::DEF_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] product;
	logic             operand_error;

	modport source (output valid, output product, output operand_error, input ready);
	modport sink (input valid, input product, input operand_error, output ready);
endinterface

@@ hw/rtl/interleaved_mod_multiplier.sv @@
// top level of the interleaved modular multiplier: control, modulus register, result register
// Computes product = multiplicand * multiplier mod modulus, scanning the multiplicand from
// its top bit down, one bit per cycle, through a row of WIDTH+3 accumulator bit slices.
// Each cycle the slices form 2*acc+x, 2*acc+x-m and 2*acc+x-2m in parallel and keep the
// largest non-negative one. The slices are loaded at the edge that accepts an item; the scan
// then steps through every multiplicand bit, and the result register is loaded in the
// transfer state that follows. A new item is taken only once the block is back in idle, and
// a result still waiting for ready holds the block in the transfer state. An operand not
// below the modulus (any operand when the modulus is zero) skips the scan and goes straight
// to the transfer state, where its zero result with operand_error set is loaded. Write
// the modulus only while no item is in flight.
module interleaved_mod_multiplier #(
	parameter int unsigned WIDTH = imm_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [WIDTH-1:0] cfg_wdata,
	imm_in_if.sink           in_ch,
	imm_out_if.source        out_ch
);

	localparam int unsigned NB = WIDTH + imm_pkg::ACC_GUARD;
	localparam int unsigned CW = $clog2(WIDTH);

	imm_pkg::state_t    state_q;
	imm_pkg::state_t    state_nx;
	imm_pkg::cell_ctl_t ctl_w;
	logic [WIDTH-1:0]   mod_q;
	logic [WIDTH-1:0]   a_q;
	logic [CW-1:0]      cnt_q;
	logic               err_q;
	logic               out_valid_q;
	logic [WIDTH-1:0]   product_q;
	logic               operand_error_q;
	logic               out_free_w;
	logic               out_load_w;
	logic               in_ready_w;
	logic               err_now_w;
	logic [NB-1:0]      m_x;
	logic [NB-1:0]      a_x;
	logic [NB-1:0]      b_x;
	logic [NB-1:0]      am_w;
	logic [NB-1:0]      bm1_w;
	logic [NB-1:0]      bm2_w;
	logic [NB-1:0]      nm1_w;
	logic [NB-1:0]      nm2_w;
	logic [NB-1:0]      acc_w;

	// load constants for the slices
	assign m_x   = NB'(mod_q);
	assign a_x   = NB'(in_ch.multiplicand);
	assign b_x   = NB'(in_ch.multiplier);
	assign am_w  = a_x - m_x;
	assign bm1_w = b_x - m_x;
	assign bm2_w = b_x - (m_x << 1);
	assign nm1_w = '0 - m_x;
	assign nm2_w = '0 - (m_x << 1);
	assign err_now_w = !am_w[NB-1] || !bm1_w[NB-1];

	assign out_free_w = !out_valid_q || out_ch.ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			imm_pkg::ST_IDLE: begin
				if (in_ch.valid) begin
					state_nx = err_now_w ? imm_pkg::ST_FIN : imm_pkg::ST_RUN;
				end
			end
			imm_pkg::ST_RUN: begin
				if (cnt_q == '0) begin
					state_nx = imm_pkg::ST_FIN;
				end
			end
			imm_pkg::ST_FIN: begin
				if (out_free_w) begin
					state_nx = imm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = imm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready_w = (state_q == imm_pkg::ST_IDLE);
		ctl_w.load = (state_q == imm_pkg::ST_IDLE) && in_ch.valid;
		ctl_w.step = (state_q == imm_pkg::ST_RUN);
		ctl_w.abit = a_q[WIDTH-1];
		out_load_w = (state_q == imm_pkg::ST_FIN) && out_free_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imm_pkg::ST_IDLE;
			mod_q       <= '0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				mod_q <= cfg_wdata;
			end
			if (ctl_w.load) begin
				cnt_q <= CW'(WIDTH - 1);
				err_q <= err_now_w;
			end else if (ctl_w.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (out_load_w) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_w.load) begin
			a_q <= in_ch.multiplicand;
		end else if (ctl_w.step) begin
			a_q <= {a_q[WIDTH-2:0], 1'b0};
		end
		if (out_load_w) begin
			product_q       <= err_q ? '0 : acc_w[WIDTH-1:0];
			operand_error_q <= err_q;
		end
	end

	imm_chain #(
		.WIDTH (WIDTH)
	) u_chain (
		.clk    (clk),
		.ctl    (ctl_w),
		.ld_b   (b_x),
		.ld_bm1 (bm1_w),
		.ld_bm2 (bm2_w),
		.ld_nm1 (nm1_w),
		.ld_nm2 (nm2_w),
		.acc    (acc_w)
	);

	assign in_ch.ready          = in_ready_w;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.product       = product_q;
	assign out_ch.operand_error = operand_error_q;

`ifndef ASSERT_OFF
	a_acc_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == imm_pkg::ST_RUN) |-> (acc_w < m_x))
		else $error("accumulator left the residue range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && operand_error_q) |-> (product_q == '0))
		else $error("error item carries a nonzero product");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == imm_pkg::ST_RUN && cnt_q == '0) |=> (state_q == imm_pkg::ST_FIN))
		else $error("scan did not finish after the last bit");

	a_no_skip_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == imm_pkg::ST_RUN) |-> !err_q)
		else $error("error item entered the scan");
`endif

endmodule

@@ hw/rtl/imm_cell.sv @@
// one bit slice of the accumulator with its three candidate adders
module imm_cell (
	input  logic                clk,
	input  imm_pkg::cell_ctl_t  ctl,
	input  imm_pkg::sel_t       sel,
	input  logic                shift_in,
	input  logic                ld_b,
	input  logic                ld_bm1,
	input  logic                ld_bm2,
	input  logic                ld_nm1,
	input  logic                ld_nm2,
	input  logic [2:0]          carry_in,
	output logic [2:0]          carry_out,
	output logic [2:0]          sum,
	output logic                acc
);

	logic       acc_q;
	logic       b_q;
	logic       bm1_q;
	logic       bm2_q;
	logic       nm1_q;
	logic       nm2_q;
	logic [2:0] x_w;
	logic [2:0] sh_w;

	// addend bit for keep, subtract once and subtract twice
	assign x_w[0] = ctl.abit & b_q;
	assign x_w[1] = ctl.abit ? bm1_q : nm1_q;
	assign x_w[2] = ctl.abit ? bm2_q : nm2_q;
	assign sh_w   = {3{shift_in}};

	assign sum       = sh_w ^ x_w ^ carry_in;
	assign carry_out = (sh_w & x_w) | (sh_w & carry_in) | (x_w & carry_in);
	assign acc       = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= 1'b0;
			b_q   <= ld_b;
			bm1_q <= ld_bm1;
			bm2_q <= ld_bm2;
			nm1_q <= ld_nm1;
			nm2_q <= ld_nm2;
		end else if (ctl.step) begin
			case (sel)
				imm_pkg::SEL_SUB2: begin
					acc_q <= sum[2];
				end
				imm_pkg::SEL_SUB1: begin
					acc_q <= sum[1];
				end
				imm_pkg::SEL_KEEP: begin
					acc_q <= sum[0];
				end
				default: begin
					acc_q <= sum[0];
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/imm_chain.sv @@
// row of accumulator bit slices with the shared reduction select
module imm_chain #(
	parameter int unsigned WIDTH = imm_pkg::DEF_WIDTH
) (
	input  logic                                   clk,
	input  imm_pkg::cell_ctl_t                     ctl,
	input  logic [WIDTH+imm_pkg::ACC_GUARD-1:0]    ld_b,
	input  logic [WIDTH+imm_pkg::ACC_GUARD-1:0]    ld_bm1,
	input  logic [WIDTH+imm_pkg::ACC_GUARD-1:0]    ld_bm2,
	input  logic [WIDTH+imm_pkg::ACC_GUARD-1:0]    ld_nm1,
	input  logic [WIDTH+imm_pkg::ACC_GUARD-1:0]    ld_nm2,
	output logic [WIDTH+imm_pkg::ACC_GUARD-1:0]    acc
);

	localparam int unsigned NB = WIDTH + imm_pkg::ACC_GUARD;

	logic [2:0]    cy_w [NB];
	logic [2:0]    sum_w [NB];
	logic [NB-1:0] sh_w;
	imm_pkg::sel_t sel_w;

	assign sh_w    = {acc[NB-2:0], 1'b0};
	assign cy_w[0] = 3'b000;

	// largest candidate that is not negative
	always_comb begin
		if (!sum_w[NB-1][2]) begin
			sel_w = imm_pkg::SEL_SUB2;
		end else if (!sum_w[NB-1][1]) begin
			sel_w = imm_pkg::SEL_SUB1;
		end else begin
			sel_w = imm_pkg::SEL_KEEP;
		end
	end

	for (genvar i = 0; i < NB; i++) begin : g_cell
		if (i < NB - 1) begin : g_mid
			imm_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.sel       (sel_w),
				.shift_in  (sh_w[i]),
				.ld_b      (ld_b[i]),
				.ld_bm1    (ld_bm1[i]),
				.ld_bm2    (ld_bm2[i]),
				.ld_nm1    (ld_nm1[i]),
				.ld_nm2    (ld_nm2[i]),
				.carry_in  (cy_w[i]),
				.carry_out (cy_w[i+1]),
				.sum       (sum_w[i]),
				.acc       (acc[i])
			);
		end else begin : g_top
			imm_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.sel       (sel_w),
				.shift_in  (sh_w[i]),
				.ld_b      (ld_b[i]),
				.ld_bm1    (ld_bm1[i]),
				.ld_bm2    (ld_bm2[i]),
				.ld_nm1    (ld_nm1[i]),
				.ld_nm2    (ld_nm2[i]),
				.carry_in  (cy_w[i]),
				.carry_out (),
				.sum       (sum_w[i]),
				.acc       (acc[i])
			);
		end
	end

endmodule

@@ tb/interleaved_mod_multiplier_tb.sv @@
// testbench for the interleaved modular multiplier: random and directed products
`timescale 1ns / 1ps

module interleaved_mod_multiplier_tb;

	localparam int unsigned W = imm_pkg::DEF_WIDTH;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [W-1:0] multiplicand;
		logic [W-1:0] multiplier;
	} operands_t;

	typedef struct packed {
		logic [W-1:0] product;
		logic         operand_error;
	} product_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [W-1:0] cfg_wdata;

	imm_in_if #(.WIDTH(W)) in_ch ();
	imm_out_if #(.WIDTH(W)) out_ch ();

	interleaved_mod_multiplier #(.WIDTH(W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	operands_t operand_queue[$];
	product_t expected_products[$];
	logic [W-1:0] modulus_copy;
	logic quiet;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned error_count;
	int unsigned cycle_count;

	always #5 clk = ~clk;

	function automatic product_t mod_product(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		product_t r;
		logic [2*W-1:0] full;
		if (a >= m || b >= m) begin
			r.product = '0;
			r.operand_error = 1'b1;
		end else begin
			full = {{W{1'b0}}, a};
			full = full * b;
			full = full % m;
			r.product = full[W-1:0];
			r.operand_error = 1'b0;
		end
		return r;
	endfunction

	function automatic int unsigned next_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic [W-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[W-1:0];
	endfunction

	function automatic logic [W-1:0] below(input logic [W-1:0] m);
		int unsigned r;
		if (m == 0)
			return rand_word();
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return m - 1'b1;
			2: return W'($urandom_range(0, 15)) % m;
			default: return rand_word() % m;
		endcase
	endfunction

	function automatic logic [W-1:0] not_below(input logic [W-1:0] m);
		logic [W-1:0] span;
		if (m == 0)
			return rand_word();
		span = ~m;
		if ($urandom_range(0, 3) == 0)
			return m;
		return m + rand_word() % (span + 1'b1);
	endfunction

	function automatic logic [W-1:0] pick_modulus();
		case ($urandom_range(0, 5))
			0: return rand_word() | (W'(1) << (W - 1));
			1: return rand_word();
			2: return W'($urandom_range(1, 1000));
			3: return W'(1) << $urandom_range(0, W - 1);
			4: return '1 - W'($urandom_range(0, 100));
			default: return W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (operand_queue.size() != 0 || in_ch.valid || expected_products.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_modulus(input logic [W-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		modulus_copy = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_pair(input logic [W-1:0] a, input logic [W-1:0] b);
		operands_t item;
		item.multiplicand = a;
		item.multiplier = b;
		operand_queue.push_back(item);
	endtask

	task automatic push_random(input int unsigned count);
		logic [W-1:0] a;
		logic [W-1:0] b;
		int unsigned r;
		for (int unsigned i = 0; i < count; i++) begin
			a = below(modulus_copy);
			b = below(modulus_copy);
			r = $urandom_range(0, 19);
			if (r == 0)
				a = not_below(modulus_copy);
			else if (r == 1)
				b = not_below(modulus_copy);
			else if (r == 2) begin
				a = not_below(modulus_copy);
				b = not_below(modulus_copy);
			end
			push_pair(a, b);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin : driver
		operands_t item;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.multiplicand <= '0;
			in_ch.multiplier <= '0;
			send_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_products.push_back(mod_product(in_ch.multiplicand, in_ch.multiplier,
					modulus_copy));
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap != 0) begin
					in_ch.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (operand_queue.size() != 0) begin
					item = operand_queue.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.multiplicand <= item.multiplicand;
					in_ch.multiplier <= item.multiplier;
					send_gap <= next_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		product_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_products.size() == 0) begin
					report_mismatch($sformatf("unexpected item product=%h error=%b",
						out_ch.product, out_ch.operand_error));
				end else begin
					want = expected_products.pop_front();
					if (out_ch.product !== want.product)
						report_mismatch($sformatf("product %h, expected %h",
							out_ch.product, want.product));
					if (out_ch.operand_error !== want.operand_error)
						report_mismatch($sformatf("operand_error %b, expected %b",
							out_ch.operand_error, want.operand_error));
				end
			end
			if (recv_stall != 0) begin
				out_ch.ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				out_ch.ready <= 1'b1;
				recv_stall <= next_gap();
			end
		end
	end

	initial begin
		logic [W-1:0] m;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n = 1'b0;
		modulus_copy = '0;
		quiet = 1'b0;
		error_count = 0;
		cycle_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// zero modulus after reset: every item is an operand error
		push_pair('0, '0);
		push_pair('1, '1);
		push_pair(W'(1), '0);

		write_modulus('1);
		m = '1;
		push_pair(m - 1'b1, m - 1'b1);
		push_pair('0, m - 1'b1);
		push_pair(m - 1'b1, W'(1));
		push_pair(m, '0);
		push_pair('0, m);
		push_pair(W'(1) << (W - 1), W'(2));

		write_modulus(W'(1));
		push_pair('0, '0);
		push_pair(W'(1), '0);
		push_pair('0, W'(1));

		write_modulus(W'(2));
		push_pair(W'(1), W'(1));
		push_pair(W'(2), W'(1));

		write_modulus((W'(1) << (W - 1)) | W'(1));
		m = (W'(1) << (W - 1)) | W'(1);
		push_pair(W'(1) << (W - 1), W'(1) << (W - 1));
		push_pair(m - 1'b1, m - 1'b1);

		write_modulus(W'(1) << (W - 1));
		m = W'(1) << (W - 1);
		push_pair(m - 1'b1, m - 1'b1);
		push_pair(m - 1'b1, W'(1));

		write_modulus('0);
		push_random(20);

		for (int unsigned phase = 0; phase < 11; phase++) begin
			write_modulus(pick_modulus());
			quiet = (phase == 3);
			if (phase == 5) begin
				// sender holds off until all results are back, then continues
				push_random(40);
				wait_idle();
				push_random(45);
			end else begin
				push_random(85);
			end
		end

		wait_idle();
		repeat (W + 8) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
